### rtl/gsnm_pkg.sv
// Package for the glob star name matcher: byte codes, register indexes,
// configuration port widths and the star closure helper.
// No dependencies.
package gsnm_pkg;

  localparam int CHAR_BITS      = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int LENGTH_BITS    = 6;
  localparam int REG_WORDS      = 4;
  localparam int REG_BYTES      = REG_WORDS * CFG_DATA_BITS / CHAR_BITS;
  localparam int TOTAL_BITS     = 16;

  localparam int DEF_MAX_PATTERN = 32;
  localparam int DEF_COUNT_BITS  = 16;

  // Widest position vector: one bit per pattern byte plus the end position.
  localparam int POS_MAX_BITS = 65;

  localparam logic [CHAR_BITS-1:0] STAR_BYTE = 8'h2A;
  localparam logic [CHAR_BITS-1:0] DOT_BYTE  = 8'h2E;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LENGTH  = 3'd0,
    REG_CHARS_A = 3'd1,
    REG_CHARS_B = 3'd2,
    REG_CHARS_C = 3'd3,
    REG_CHARS_D = 3'd4
  } cfg_reg_t;

  // Carry each live position forward across runs of stars. Works as an adder
  // carry chain: a star propagates, a live position on a star generates.
  function automatic logic [POS_MAX_BITS-1:0] star_closure(
    input logic [POS_MAX_BITS-1:0] live,
    input logic [POS_MAX_BITS-1:0] stars
  );
    logic [POS_MAX_BITS-1:0] gen;
    logic [POS_MAX_BITS-1:0] sum;
    gen = live & stars;
    sum = gen + stars;
    return live | (sum ^ gen ^ stars);
  endfunction

endpackage

### rtl/gsnm_cfg.sv
// Pattern registers and derived masks (bytes in use, stars, end position,
// start positions) for the glob star name matcher. Uses gsnm_pkg.
// Masks settle after a write to a pattern register; busy covers that window.
module gsnm_cfg import gsnm_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
  input  logic [CFG_DATA_BITS-1:0]               cfg_data,
  output logic [MAX_PATTERN-1:0][CHAR_BITS-1:0]  pat_bytes,
  output logic [MAX_PATTERN-1:0]                 use_mask,
  output logic [MAX_PATTERN-1:0]                 star_mask,
  output logic [MAX_PATTERN:0]                   end_mask,
  output logic [MAX_PATTERN:0]                   start_pos,
  output logic                                   busy,
  output logic                                   count_clear
);

  localparam int PW = MAX_PATTERN + 1;
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  logic [LENGTH_BITS-1:0]                       pattern_length;
  logic [REG_WORDS-1:0][CFG_DATA_BITS-1:0]      chars;
  logic [1:0]                                   settle;

  logic [PW-1:0]          zero_pos;
  logic [PW-1:0]          first_zero;
  logic [PW-1:0]          prefix;
  logic [MAX_PATTERN-1:0] len_mask;
  logic [MAX_PATTERN-1:0] use_next;
  logic [MAX_PATTERN-1:0] star_next;

  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_bytes
      if (g < REG_BYTES) begin : g_stored
        assign pat_bytes[g] = chars[g / 8][(g % 8) * CHAR_BITS +: CHAR_BITS];
      end else begin : g_beyond
        assign pat_bytes[g] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      chars          <= '0;
      settle         <= SETTLE_CYCLES;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LENGTH: begin
          pattern_length <= cfg_data[LENGTH_BITS-1:0];
          settle         <= SETTLE_CYCLES;
        end
        REG_CHARS_A: begin
          chars[0] <= cfg_data;
          settle   <= SETTLE_CYCLES;
        end
        REG_CHARS_B: begin
          chars[1] <= cfg_data;
          settle   <= SETTLE_CYCLES;
        end
        REG_CHARS_C: begin
          chars[2] <= cfg_data;
          settle   <= SETTLE_CYCLES;
        end
        REG_CHARS_D: begin
          chars[3] <= cfg_data;
          settle   <= SETTLE_CYCLES;
        end
        default: begin
          if (settle != '0) begin
            settle <= settle - 2'd1;
          end
        end
      endcase
    end else if (settle != '0) begin
      settle <= settle - 2'd1;
    end
  end

  assign busy        = (settle != '0);
  assign count_clear = cfg_valid && (cfg_reg_t'(cfg_index) == REG_LENGTH);

  // Pattern ends at the first zero byte, the length register or MAX_PATTERN.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      zero_pos[i] = (pat_bytes[i] == '0);
      len_mask[i] = (i < int'(pattern_length));
    end
    zero_pos[MAX_PATTERN] = 1'b1;
    first_zero = zero_pos & (~zero_pos + PW'(1));
    prefix     = first_zero - PW'(1);
    use_next   = prefix[MAX_PATTERN-1:0] & len_mask;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      star_next[i] = use_next[i] && (pat_bytes[i] == STAR_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    use_mask  <= use_next;
    star_mask <= star_next;
    end_mask  <= {1'b0, use_next} + PW'(1);
    start_pos <= PW'(star_closure(POS_MAX_BITS'(1), POS_MAX_BITS'(star_mask)));
  end

endmodule

### rtl/glob_star_name_matcher.sv
// Glob star name matcher: one name byte per cycle against a '*' pattern.
// The result word is registered: it appears in the cycle after the last byte of a name is accepted.
// Throughput: one byte per cycle; input stalls while a result is held and
// the next byte also ends a name.
// After reset and after each write to a defined register the input stalls
// while the pattern masks settle. Reset clears count and name state.
module glob_star_name_matcher import gsnm_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CHAR_BITS-1:0]      name_char,
  input  logic                      name_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      name_matches,
  output logic [TOTAL_BITS-1:0]     match_total,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PW = MAX_PATTERN + 1;

  logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] pat_bytes;
  logic [MAX_PATTERN-1:0] use_mask;
  logic [MAX_PATTERN-1:0] star_mask;
  logic [PW-1:0]          end_mask;
  logic [PW-1:0]          start_pos;
  logic                   busy;
  logic                   count_clear;

  logic [PW-1:0]          active;
  logic                   at_start;
  logic                   hidden;
  logic [COUNT_BITS-1:0]  count;

  logic [PW-1:0]          cur;
  logic [MAX_PATTERN-1:0] char_eq;
  logic [MAX_PATTERN-1:0] live;
  logic [PW-1:0]          raw_next;
  logic [PW-1:0]          active_next;
  logic                   hidden_now;
  logic                   match;
  logic [COUNT_BITS-1:0]  count_next;
  logic                   accept;

  gsnm_cfg #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pat_bytes  (pat_bytes),
    .use_mask   (use_mask),
    .star_mask  (star_mask),
    .end_mask   (end_mask),
    .start_pos  (start_pos),
    .busy       (busy),
    .count_clear(count_clear)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = busy || (out_valid && out_stall && name_last);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cur = at_start ? start_pos : active;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      char_eq[i] = (pat_bytes[i] == name_char);
    end
    live = cur[MAX_PATTERN-1:0] & use_mask;
    // stars hold their position, literal hits step to the next one
    raw_next = {1'b0, live & star_mask} | {live & ~star_mask & char_eq, 1'b0};
    active_next = PW'(star_closure(POS_MAX_BITS'(raw_next), POS_MAX_BITS'(star_mask)));
    hidden_now  = at_start ? (name_char == DOT_BYTE) : hidden;
    match       = !hidden_now && ((active_next & end_mask) != '0);
    count_next  = (match && (count != '1)) ? count + COUNT_BITS'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start  <= 1'b1;
      hidden    <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (count_clear) begin
        count <= '0;
      end else if (accept && name_last) begin
        count <= count_next;
      end
      if (accept) begin
        at_start <= name_last;
        hidden   <= name_last ? 1'b0 : hidden_now;
      end
      if (accept && name_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      active <= active_next;
    end
    if (accept && name_last) begin
      name_matches <= match;
      match_total  <= TOTAL_BITS'(count_next);
    end
  end

endmodule
